>>> src/rmq_pkg.sv
package rmq_pkg;

    // bits of the radicand consumed per square-root step
    localparam int ROOT_STEP = 2;

    typedef enum logic [1:0] {
        BIG_W,
        BIG_X,
        BIG_Y,
        BIG_Z
    } t_big;

endpackage

>>> src/rmq_if.sv
interface rmq_mat_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m11;
    logic signed [DATA_WIDTH-1:0] m12;
    logic signed [DATA_WIDTH-1:0] m13;
    logic signed [DATA_WIDTH-1:0] m21;
    logic signed [DATA_WIDTH-1:0] m22;
    logic signed [DATA_WIDTH-1:0] m23;
    logic signed [DATA_WIDTH-1:0] m31;
    logic signed [DATA_WIDTH-1:0] m32;
    logic signed [DATA_WIDTH-1:0] m33;

    modport source (
        output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
        input  ready
    );
    modport sink (
        input  valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
        output ready
    );
endinterface

interface rmq_quat_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

>>> src/rmq_sqrt.sv
module rmq_sqrt #(
    parameter int LANES = 4,
    parameter int IN_W  = 46,
    parameter int TAG_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [IN_W-1:0]     i_rad  [LANES],
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_vld,
    output logic [IN_W/2-1:0]   o_root [LANES],
    output logic [TAG_W-1:0]    o_tag
);
    import rmq_pkg::*;

    localparam int RW = IN_W / 2;

    logic            r_vld  [RW];
    logic [IN_W-1:0] r_rad  [RW][LANES];
    logic [RW+1:0]   r_rem  [RW][LANES];
    logic [RW-1:0]   r_root [RW][LANES];
    logic [TAG_W-1:0] r_tag [RW];

    // one root bit per stage, restoring
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic             p_vld;
        logic [IN_W-1:0]  p_rad  [LANES];
        logic [RW+1:0]    p_rem  [LANES];
        logic [RW-1:0]    p_root [LANES];
        logic [TAG_W-1:0] p_tag;
        logic [IN_W-1:0]  n_rad  [LANES];
        logic [RW+1:0]    n_rem  [LANES];
        logic [RW-1:0]    n_root [LANES];
        logic [RW+1:0]    sh     [LANES];
        logic [RW+1:0]    trial  [LANES];

        if (k == 0) begin : g_in
            always_comb begin
                p_vld = i_vld;
                p_tag = i_tag;
                for (int l = 0; l < LANES; l++) begin
                    p_rad[l]  = i_rad[l];
                    p_rem[l]  = '0;
                    p_root[l] = '0;
                end
            end
        end else begin : g_link
            always_comb begin
                p_vld = r_vld[k-1];
                p_tag = r_tag[k-1];
                for (int l = 0; l < LANES; l++) begin
                    p_rad[l]  = r_rad[k-1][l];
                    p_rem[l]  = r_rem[k-1][l];
                    p_root[l] = r_root[k-1][l];
                end
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                sh[l]    = {p_rem[l][RW-1:0], p_rad[l][IN_W-1 -: ROOT_STEP]};
                trial[l] = {p_root[l], ROOT_STEP'(1)};
                n_rad[l] = p_rad[l] << ROOT_STEP;
                if (sh[l] >= trial[l]) begin
                    n_rem[l]  = sh[l] - trial[l];
                    n_root[l] = {p_root[l][RW-2:0], 1'b1};
                end else begin
                    n_rem[l]  = sh[l];
                    n_root[l] = {p_root[l][RW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= p_tag;
                for (int l = 0; l < LANES; l++) begin
                    r_rad[k][l]  <= n_rad[l];
                    r_rem[k][l]  <= n_rem[l];
                    r_root[k][l] <= n_root[l];
                end
            end
        end
    end

    always_comb begin
        o_vld = r_vld[RW-1];
        o_tag = r_tag[RW-1];
        for (int l = 0; l < LANES; l++) begin
            o_root[l] = r_root[RW-1][l];
        end
    end

endmodule

>>> src/rmq_div.sv
module rmq_div #(
    parameter int LANES = 4,
    parameter int DEN_W = 24,
    parameter int Q_W   = 15,
    parameter int TAG_W = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [DEN_W+Q_W-2:0]   i_num  [LANES],
    input  logic [DEN_W-1:0]       i_den,
    input  logic [TAG_W-1:0]       i_tag,
    output logic                   o_vld,
    output logic [Q_W-1:0]         o_quot [LANES],
    output logic [TAG_W-1:0]       o_tag
);
    localparam int NUM_W = DEN_W + Q_W - 1;

    logic             r_vld [Q_W];
    logic [DEN_W-1:0] r_rem [Q_W][LANES];
    logic [Q_W-1:0]   r_qr  [Q_W][LANES];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [TAG_W-1:0] r_tag [Q_W];

    // qr holds the dividend bits still to come on top, quotient bits fill from below
    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic             p_vld;
        logic [DEN_W-1:0] p_rem [LANES];
        logic [Q_W-1:0]   p_qr  [LANES];
        logic [DEN_W-1:0] p_den;
        logic [TAG_W-1:0] p_tag;
        logic [DEN_W:0]   sh    [LANES];
        logic [DEN_W-1:0] n_rem [LANES];
        logic [Q_W-1:0]   n_qr  [LANES];

        if (k == 0) begin : g_in
            always_comb begin
                p_vld = i_vld;
                p_den = i_den;
                p_tag = i_tag;
                for (int l = 0; l < LANES; l++) begin
                    p_rem[l] = DEN_W'(i_num[l][NUM_W-1 -: DEN_W-1]);
                    p_qr[l]  = i_num[l][Q_W-1:0];
                end
            end
        end else begin : g_link
            always_comb begin
                p_vld = r_vld[k-1];
                p_den = r_den[k-1];
                p_tag = r_tag[k-1];
                for (int l = 0; l < LANES; l++) begin
                    p_rem[l] = r_rem[k-1][l];
                    p_qr[l]  = r_qr[k-1][l];
                end
            end
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                sh[l] = {p_rem[l], p_qr[l][Q_W-1]};
                if (sh[l] >= {1'b0, p_den}) begin
                    n_rem[l] = DEN_W'(sh[l] - {1'b0, p_den});
                    n_qr[l]  = {p_qr[l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = sh[l][DEN_W-1:0];
                    n_qr[l]  = {p_qr[l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= p_den;
                r_tag[k] <= p_tag;
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= n_rem[l];
                    r_qr[k][l]  <= n_qr[l];
                end
            end
        end
    end

    always_comb begin
        o_vld = r_vld[Q_W-1];
        o_tag = r_tag[Q_W-1];
        for (int l = 0; l < LANES; l++) begin
            o_quot[l] = r_qr[Q_W-1][l];
        end
    end

endmodule

>>> src/rotation_matrix_to_quaternion_unit.sv
// Throughput: one matrix per cycle while the 2-entry output queue is not full; the
//   queue absorbs sink stalls, and when it is full all stages hold. The root, norm
//   root and divider pipelines each take one result bit per stage.
// Reset: synchronous active low, clears all stage valid bits and the output queue.
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH    = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rmq_mat_if.sink    i_mat,
    rmq_quat_if.source o_quat
);
    import rmq_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int SW    = DW + 1;          // clamped diagonal sum
    localparam int SSW   = DW + 3;          // signed diagonal sum
    localparam int TW    = F + (DW + 2) / 2; // per-component root
    localparam int SQW   = 2 * TW;
    localparam int NW    = TW + 1;          // norm
    localparam int QW    = F + 1;           // magnitude
    localparam int NUMW  = TW + F + 1;

    logic en;

    // ---------------- stage A: diagonal sums and sign candidates
    logic signed [SSW-1:0] a11, a22, a33, one_s;
    logic signed [SSW-1:0] sd [4];
    logic [SW-1:0]         n_a_s [4];
    logic [5:0]            n_a_f;
    logic                  r_a_vld;
    logic [SW-1:0]         r_a_s [4];
    logic [5:0]            r_a_f;

    function automatic logic neg_sum(input logic signed [DW-1:0] p,
                                     input logic signed [DW-1:0] q,
                                     input logic sub);
        logic signed [DW:0] d;
        d = sub ? (DW+1)'(p) - (DW+1)'(q) : (DW+1)'(p) + (DW+1)'(q);
        return d[DW];
    endfunction

    always_comb begin
        a11   = SSW'(i_mat.m11);
        a22   = SSW'(i_mat.m22);
        a33   = SSW'(i_mat.m33);
        one_s = SSW'(1) <<< F;
        sd[0] =  a11 + a22 + a33 + one_s;
        sd[1] =  a11 - a22 - a33 + one_s;
        sd[2] = -a11 + a22 - a33 + one_s;
        sd[3] = -a11 - a22 + a33 + one_s;
        for (int i = 0; i < 4; i++) begin
            n_a_s[i] = sd[i][SSW-1] ? '0 : sd[i][SW-1:0];
        end
        n_a_f[0] = neg_sum(i_mat.m32, i_mat.m23, 1'b1);
        n_a_f[1] = neg_sum(i_mat.m13, i_mat.m31, 1'b1);
        n_a_f[2] = neg_sum(i_mat.m21, i_mat.m12, 1'b1);
        n_a_f[3] = neg_sum(i_mat.m21, i_mat.m12, 1'b0);
        n_a_f[4] = neg_sum(i_mat.m13, i_mat.m31, 1'b0);
        n_a_f[5] = neg_sum(i_mat.m32, i_mat.m23, 1'b0);
    end

    // ---------------- stage B: largest component and signs
    t_big          big;
    logic [3:0]    n_b_neg;
    logic          r_b_vld;
    logic [SW-1:0] r_b_s [4];
    logic [3:0]    r_b_neg;

    always_comb begin
        if (r_a_s[0] >= r_a_s[1] && r_a_s[0] >= r_a_s[2] && r_a_s[0] >= r_a_s[3]) begin
            big = BIG_W;
        end else if (r_a_s[1] >= r_a_s[2] && r_a_s[1] >= r_a_s[3]) begin
            big = BIG_X;
        end else if (r_a_s[2] >= r_a_s[3]) begin
            big = BIG_Y;
        end else begin
            big = BIG_Z;
        end
        case (big)
            BIG_W:   n_b_neg = {r_a_f[2], r_a_f[1], r_a_f[0], 1'b0};
            BIG_X:   n_b_neg = {r_a_f[4], r_a_f[3], 1'b0, r_a_f[0]};
            BIG_Y:   n_b_neg = {r_a_f[5], 1'b0, r_a_f[3], r_a_f[1]};
            BIG_Z:   n_b_neg = {1'b0, r_a_f[5], r_a_f[4], r_a_f[2]};
            default: n_b_neg = '0;
        endcase
    end

    // ---------------- component roots
    logic [SQW-1:0] rad1 [4];
    logic           s1_vld;
    logic [TW-1:0]  s1_t [4];
    logic [3:0]     s1_neg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rad1[i] = SQW'(r_b_s[i]) << (2 * F);
        end
    end

    rmq_sqrt #(.LANES(4), .IN_W(SQW), .TAG_W(4)) u_root (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_b_vld),
        .i_rad  (rad1),
        .i_tag  (r_b_neg),
        .o_vld  (s1_vld),
        .o_root (s1_t),
        .o_tag  (s1_neg)
    );

    // ---------------- stages C, D, E: sum of squares
    logic           r_c_vld, r_d_vld, r_e_vld;
    logic [SQW-1:0] r_c_sq [4];
    logic [TW-1:0]  r_c_t [4], r_d_t [4], r_e_t [4];
    logic [3:0]     r_c_neg, r_d_neg, r_e_neg;
    logic [SQW:0]   r_d_sum01, r_d_sum23;
    logic [SQW+1:0] r_e_sum;

    // ---------------- norm root
    logic [SQW+1:0]    rad2 [1];
    logic [4*TW+3:0]   tag2, s2_tag;
    logic              s2_vld;
    logic [NW-1:0]     s2_n [1];
    logic [NW-1:0]     nrm;
    logic [NUMW-1:0]   n_f_num [4];

    always_comb begin
        rad2[0] = r_e_sum;
        tag2    = {r_e_neg, r_e_t[3], r_e_t[2], r_e_t[1], r_e_t[0]};
    end

    rmq_sqrt #(.LANES(1), .IN_W(SQW + 2), .TAG_W(4 * TW + 4)) u_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_e_vld),
        .i_rad  (rad2),
        .i_tag  (tag2),
        .o_vld  (s2_vld),
        .o_root (s2_n),
        .o_tag  (s2_tag)
    );

    // ---------------- stage F: rounded dividends
    logic            r_f_vld;
    logic [NUMW-1:0] r_f_num [4];
    logic [NW-1:0]   r_f_den;
    logic [3:0]      r_f_neg;

    always_comb begin
        nrm = (s2_n[0] == '0) ? NW'(1) : s2_n[0];
        for (int i = 0; i < 4; i++) begin
            n_f_num[i] = (NUMW'(s2_tag[i*TW +: TW]) << F) + NUMW'(nrm >> 1);
        end
    end

    // ---------------- divide by norm
    logic          dv_vld;
    logic [QW-1:0] dv_q [4];
    logic [3:0]    dv_neg;

    rmq_div #(.LANES(4), .DEN_W(NW), .Q_W(QW), .TAG_W(4)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_vld  (r_f_vld),
        .i_num  (r_f_num),
        .i_den  (r_f_den),
        .i_tag  (r_f_neg),
        .o_vld  (dv_vld),
        .o_quot (dv_q),
        .o_tag  (dv_neg)
    );

    // ---------------- output queue, two entries
    logic [DW-1:0] qd [4];
    logic [DW-1:0] r_e0 [4], r_e1 [4];
    logic [1:0]    r_cnt;
    logic          push, pop;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qd[i] = dv_neg[i] ? DW'(0) - DW'(dv_q[i]) : DW'(dv_q[i]);
        end
    end

    assign en          = (r_cnt != 2'd2);
    assign i_mat.ready = en;
    assign push        = dv_vld && en;
    assign pop         = o_quat.valid && o_quat.ready;

    assign o_quat.valid  = (r_cnt != 2'd0);
    assign o_quat.quat_w = r_e0[0];
    assign o_quat.quat_x = r_e0[1];
    assign o_quat.quat_y = r_e0[2];
    assign o_quat.quat_z = r_e0[3];

    // ---------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_mat.valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= s1_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_f   <= n_a_f;
            r_b_neg <= n_b_neg;
            r_c_neg <= s1_neg;
            r_d_neg <= r_c_neg;
            r_e_neg <= r_d_neg;
            r_f_neg <= s2_tag[4*TW +: 4];
            r_f_den <= nrm;
            r_d_sum01 <= (SQW+1)'(r_c_sq[0]) + (SQW+1)'(r_c_sq[1]);
            r_d_sum23 <= (SQW+1)'(r_c_sq[2]) + (SQW+1)'(r_c_sq[3]);
            r_e_sum   <= (SQW+2)'(r_d_sum01) + (SQW+2)'(r_d_sum23);
            for (int i = 0; i < 4; i++) begin
                r_a_s[i]   <= n_a_s[i];
                r_b_s[i]   <= r_a_s[i];
                r_c_sq[i]  <= SQW'(s1_t[i]) * SQW'(s1_t[i]);
                r_c_t[i]   <= s1_t[i];
                r_d_t[i]   <= r_c_t[i];
                r_e_t[i]   <= r_d_t[i];
                r_f_num[i] <= n_f_num[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({push, pop})
            2'b10: begin
                if (r_cnt == 2'd0) begin
                    r_e0 <= qd;
                end else begin
                    r_e1 <= qd;
                end
            end
            2'b01:   r_e0 <= r_e1;
            2'b11: begin
                if (r_cnt == 2'd1) begin
                    r_e0 <= qd;
                end else begin
                    r_e0 <= r_e1;
                    r_e1 <= qd;
                end
            end
            default: r_e0 <= r_e0;
        endcase
    end

`ifndef SYNTHESIS
    localparam logic signed [DW-1:0] ONE_Q = DW'(1) << F;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output queue count out of range");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!i_mat.ready && !push))
        else $error("transfer while output queue full");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && en) |=> r_b_vld)
        else $error("item lost between first stages");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_quat.valid |-> (o_quat.quat_w <= ONE_Q && o_quat.quat_w >= -ONE_Q &&
                          o_quat.quat_x <= ONE_Q && o_quat.quat_x >= -ONE_Q &&
                          o_quat.quat_y <= ONE_Q && o_quat.quat_y >= -ONE_Q &&
                          o_quat.quat_z <= ONE_Q && o_quat.quat_z >= -ONE_Q))
        else $error("quaternion component above unit magnitude");
`endif

endmodule

>>> verif/rotation_matrix_to_quaternion_unit_tb.sv
module rotation_matrix_to_quaternion_unit_tb;

    import rmq_pkg::*;

    localparam int DW      = 16;
    localparam int FB      = 14;
    localparam int ONE     = 1 << FB;
    localparam int LATENCY = 69;
    localparam int LIMIT   = 2000000;

    typedef logic signed [DW-1:0] t_word;

    typedef struct packed {
        t_word m11, m12, m13, m21, m22, m23, m31, m32, m33;
    } t_mat;

    typedef struct packed {
        t_word w, x, y, z;
    } t_quat;

    typedef struct {
        t_mat  mat;
        logic  fixed;
        t_quat quat;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    bit   failed;
    int   cycle;
    int   src_idle_pct;
    int   snk_stall_pct;

    rmq_mat_if  #(.DATA_WIDTH(DW)) mat_bus ();
    rmq_quat_if #(.DATA_WIDTH(DW)) quat_bus ();

    rotation_matrix_to_quaternion_unit #(
        .DATA_WIDTH   (DW),
        .FRACTION_BITS(FB)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_mat  (mat_bus.sink),
        .o_quat (quat_bus.source)
    );

    t_quat quat_expected[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_quat quat_of_matrix(t_mat m);
        longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
        longint s[4];
        longint unsigned t[4];
        longint unsigned sumsq, n, mag;
        bit neg[4];
        t_big big;
        t_word res[4];
        t_quat q;
        a11 = m.m11; a12 = m.m12; a13 = m.m13;
        a21 = m.m21; a22 = m.m22; a23 = m.m23;
        a31 = m.m31; a32 = m.m32; a33 = m.m33;
        s[0] = a11 + a22 + a33 + ONE;
        s[1] = a11 - a22 - a33 + ONE;
        s[2] = -a11 + a22 - a33 + ONE;
        s[3] = -a11 - a22 + a33 + ONE;
        sumsq = 0;
        for (int i = 0; i < 4; i++) begin
            if (s[i] < 0) s[i] = 0;
            t[i] = int_sqrt(longint'(s[i]) << 28);
            sumsq += t[i] * t[i];
            neg[i] = 1'b0;
        end
        if (s[0] >= s[1] && s[0] >= s[2] && s[0] >= s[3]) big = BIG_W;
        else if (s[1] >= s[2] && s[1] >= s[3])            big = BIG_X;
        else if (s[2] >= s[3])                            big = BIG_Y;
        else                                              big = BIG_Z;
        case (big)
            BIG_W: begin
                neg[1] = (a32 - a23) < 0;
                neg[2] = (a13 - a31) < 0;
                neg[3] = (a21 - a12) < 0;
            end
            BIG_X: begin
                neg[0] = (a32 - a23) < 0;
                neg[2] = (a21 + a12) < 0;
                neg[3] = (a13 + a31) < 0;
            end
            BIG_Y: begin
                neg[0] = (a13 - a31) < 0;
                neg[1] = (a21 + a12) < 0;
                neg[3] = (a32 + a23) < 0;
            end
            default: begin
                neg[0] = (a21 - a12) < 0;
                neg[1] = (a31 + a13) < 0;
                neg[2] = (a32 + a23) < 0;
            end
        endcase
        n = int_sqrt(sumsq);
        if (n == 0) n = 1;
        for (int i = 0; i < 4; i++) begin
            mag = (t[i] * ONE + (n >> 1)) / n;
            res[i] = neg[i] ? t_word'(-mag) : t_word'(mag);
        end
        q.w = res[0]; q.x = res[1]; q.y = res[2]; q.z = res[3];
        return q;
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0:       return t_word'(16'h8000);
            1:       return t_word'(16'h7fff);
            2:       return t_word'($urandom_range(0, 2 * ONE)) - t_word'(ONE);
            default: return t_word'($urandom);
        endcase
    endfunction

    // three in four: diagonal of random sign and magnitude up to one, off-diagonal from rand_word; else all random
    function automatic t_mat rand_mat();
        t_mat m;
        m = t_mat'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 3) != 0) begin
            m.m11 = t_word'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, ONE)));
            m.m22 = t_word'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, ONE)));
            m.m33 = t_word'(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, ONE)));
            m.m12 = rand_word(); m.m13 = rand_word(); m.m21 = rand_word();
            m.m23 = rand_word(); m.m31 = rand_word(); m.m32 = rand_word();
        end
        return m;
    endfunction

    task automatic send_matrix(t_mat m);
        while (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            mat_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        mat_bus.valid <= 1'b1;
        {mat_bus.m11, mat_bus.m12, mat_bus.m13, mat_bus.m21, mat_bus.m22,
         mat_bus.m23, mat_bus.m31, mat_bus.m32, mat_bus.m33} <= m;
        do @(posedge i_clk); while (!mat_bus.ready);
        quat_expected.push_back(quat_of_matrix(m));
        @(negedge i_clk);
    endtask

    initial begin
        quat_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            quat_bus.ready <= !(snk_stall_pct > 0 && $urandom_range(0, 99) < snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_quat got, want;
        cycle <= cycle + 1;
        if (i_rst_n && quat_bus.valid && quat_bus.ready) begin
            got = {quat_bus.quat_w, quat_bus.quat_x, quat_bus.quat_y, quat_bus.quat_z};
            if (quat_expected.size() == 0) begin
                $error("unexpected quaternion %h", got);
                failed = 1'b1;
            end else begin
                want = quat_expected.pop_front();
                if (got.w !== want.w) begin
                    $error("quat_w expected %0d actual %0d", want.w, got.w); failed = 1'b1;
                end
                if (got.x !== want.x) begin
                    $error("quat_x expected %0d actual %0d", want.x, got.x); failed = 1'b1;
                end
                if (got.y !== want.y) begin
                    $error("quat_y expected %0d actual %0d", want.y, got.y); failed = 1'b1;
                end
                if (got.z !== want.z) begin
                    $error("quat_z expected %0d actual %0d", want.z, got.z); failed = 1'b1;
                end
            end
        end
        if (cycle > LIMIT) begin
            $display("rotation_matrix_to_quaternion_unit_tb: errors");
            $finish;
        end
    end

    t_row rows[$];

    task automatic add_row(t_mat m, logic fixed, t_quat q);
        t_row r;
        r.mat = m; r.fixed = fixed; r.quat = q;
        rows.push_back(r);
    endtask

    initial begin
        t_word k;
        cycle = 0;
        failed = 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        mat_bus.valid = 1'b0;
        {mat_bus.m11, mat_bus.m12, mat_bus.m13, mat_bus.m21, mat_bus.m22,
         mat_bus.m23, mat_bus.m31, mat_bus.m32, mat_bus.m33} = '0;
        k = t_word'(ONE);
        // identity and the three half-turns: one component largest each
        add_row('{k, 0, 0, 0, k, 0, 0, 0, k}, 1'b1, '{k, 0, 0, 0});
        add_row('{k, 0, 0, 0, -k, 0, 0, 0, -k}, 1'b1, '{0, k, 0, 0});
        add_row('{-k, 0, 0, 0, k, 0, 0, 0, -k}, 1'b1, '{0, 0, k, 0});
        add_row('{-k, 0, 0, 0, -k, 0, 0, 0, k}, 1'b1, '{0, 0, 0, k});
        // all zero: all s equal, tie goes to w
        add_row('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{8192, 8192, 8192, 8192});
        add_row('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, '0);
        add_row('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff}, 1'b0, '0);
        add_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                  16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}, 1'b0, '0);
        add_row('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}, 1'b0, '0);
        // off-diagonal sums and differences zero and negative, each component largest: sign(0) = +
        add_row('{k, 100, -100, 100, k, 100, 100, 100, k}, 1'b0, '0);
        add_row('{k, 100, 200, -100, k, 300, -200, -300, k}, 1'b0, '0);
        add_row('{k, 0, 0, 0, -k, -100, 0, -200, -k}, 1'b0, '0);
        add_row('{-k, -50, 0, -60, k, 0, 0, 0, -k}, 1'b0, '0);
        add_row('{-k, 0, -70, 0, -k, 20, -80, -30, k}, 1'b0, '0);
        // 90 degrees about z
        add_row('{0, -k, 0, k, 0, 0, 0, 0, k}, 1'b0, '0);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) begin
            send_matrix(rows[i].mat);
            if (rows[i].fixed && quat_expected[$] !== rows[i].quat) begin
                $error("quaternion expected %h predicted %h", rows[i].quat, quat_expected[$]);
                failed = 1'b1;
            end
        end
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 76; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 76; end
                default: begin src_idle_pct = 20; snk_stall_pct = 20; end
            endcase
            repeat (250) send_matrix(rand_mat());
        end
        mat_bus.valid <= 1'b0;
        while (quat_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (!failed)
            $display("rotation_matrix_to_quaternion_unit_tb: clean");
        else
            $display("rotation_matrix_to_quaternion_unit_tb: errors");
        $finish;
    end

endmodule
